[sv/lphs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package lphs_pkg;

  localparam int KEY_W  = 31;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;
  localparam int CFG_W  = 5;
  localparam int CNT_W  = 5;

  localparam int SLOTS_DEFAULT = 16;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USED  = 2'd1;
  localparam logic [1:0] ST_GONE  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

  typedef struct packed {
    logic              found;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot_used;
  } res_t;

endpackage
`default_nettype wire

[sv/lphs_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface lphs_req_if;
  logic                          valid;
  logic                          ready;
  logic [lphs_pkg::MODE_W-1:0]   mode;
  logic [lphs_pkg::KEY_W-1:0]    key;

  modport source (output valid, mode, key, input ready);
  modport sink   (input valid, mode, key, output ready);
endinterface

interface lphs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [lphs_pkg::STAT_W-1:0]   status;
  logic [lphs_pkg::SLOT_W-1:0]   slot_used;

  modport source (output valid, found, status, slot_used, input ready);
  modport sink   (input valid, found, status, slot_used, output ready);
endinterface
`default_nettype wire

[sv/lphs_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[sv/lphs_mod.sv]
`timescale 1ns / 1ps
`default_nettype none
// restoring remainder, one dividend bit per cycle
module lphs_mod (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [lphs_pkg::KEY_W-1:0]   dividend,
  input  wire logic [lphs_pkg::CFG_W-1:0]   divisor,
  output logic                              done,
  output logic      [lphs_pkg::CFG_W-1:0]   rem
);

  localparam int CW = lphs_pkg::CFG_W;
  localparam logic [CW-1:0] LAST = CW'(lphs_pkg::KEY_W - 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [lphs_pkg::KEY_W-1:0] shreg;
  logic [CW-1:0]     dvs;
  logic [CW:0]       trial;
  logic [CW-1:0]     rem_next;

  always_comb begin
    trial = {rem, shreg[lphs_pkg::KEY_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = CW'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[lphs_pkg::KEY_W-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

endmodule
`default_nettype wire

[sv/linear_probing_hash_set.sv]
`timescale 1ns / 1ps
`default_nettype none
// Linear-probing hash set. Each request beat carries a mode (insert, search,
// remove) and a 31-bit key and yields exactly one response beat. The home slot
// is key mod slots_in_use (0 acts as 1, values above SLOTS act as SLOTS; at
// most 31 slots are ever probed); probing steps one slot at a time with wrap.
// Insert does not check duplicates and reports table full when no empty or
// deleted slot exists; remove leaves a tombstone. One request at a time:
// the shared bit-serial remainder unit (31 bit steps and its registered
// done), then a key RAM registered read and a compare per probed slot,
// up to n probes, plus the issue and response states. An unused mode goes
// straight from issue to response, reporting absent. Slot states reset at
// once; no clearing pass is needed.
// slots_in_use may only be written while the block is idle.
module linear_probing_hash_set #(
  parameter int SLOTS = lphs_pkg::SLOTS_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [lphs_pkg::CFG_W-1:0]    cfg_data,
  lphs_req_if.sink                           req,
  lphs_rsp_if.source                         rsp
);

  localparam int DEPTH = (SLOTS < 31) ? SLOTS : 31;
  localparam int IW    = $clog2(DEPTH);
  localparam int CW    = lphs_pkg::CFG_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]                       state;
  logic [CW-1:0]                    cfg;
  logic [CW-1:0]                    n_eff;
  logic [lphs_pkg::MODE_W-1:0]      mode;
  logic [lphs_pkg::KEY_W-1:0]       key;
  logic [IW-1:0]                    idx;
  logic [lphs_pkg::CNT_W-1:0]       cnt;
  lphs_pkg::res_t                   res;
  logic                             div_start;
  logic                             div_done;
  logic [CW-1:0]                    div_rem;
  logic [lphs_pkg::KEY_W-1:0]       key_rd;
  logic                             key_we;
  logic [1:0]                       slot_status [DEPTH];
  logic [1:0]                       st;
  logic [CW:0]                      idx_inc;
  logic                             wrap;
  logic                             last_probe;
  logic [31:0]                      idx_w;
  logic [lphs_pkg::SLOT_W-1:0]      slot_out;
  logic                             hit;

  assign n_eff = (cfg == '0) ? CW'(1) : ((cfg > DEPTH_C) ? DEPTH_C : cfg);

  assign div_start = req.valid && req.ready &&
                     (req.mode == lphs_pkg::MODE_INSERT ||
                      req.mode == lphs_pkg::MODE_SEARCH ||
                      req.mode == lphs_pkg::MODE_REMOVE);

  lphs_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.key),
    .divisor  (n_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign key_we = (state == S_CHECK) && (mode == lphs_pkg::MODE_INSERT) &&
                  (st != lphs_pkg::ST_USED);

  lphs_ram #(
    .WIDTH (lphs_pkg::KEY_W),
    .DEPTH (DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .addr  (idx),
    .wdata (key),
    .rdata (key_rd)
  );

  assign st         = slot_status[idx];
  assign idx_inc    = (CW+1)'(idx) + (CW+1)'(1);
  assign wrap       = idx_inc == {1'b0, n_eff};
  assign last_probe = ((CW+1)'(cnt) + (CW+1)'(1)) == {1'b0, n_eff};
  assign idx_w      = 32'(idx);
  assign slot_out   = idx_w[lphs_pkg::SLOT_W-1:0];
  assign hit        = (st == lphs_pkg::ST_USED) && (key_rd == key);

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= lphs_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        slot_status[i] <= lphs_pkg::ST_EMPTY;
      end
    end else begin
      if (rsp.valid && rsp.ready && (state != S_FIN)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode <= req.mode;
            key  <= req.key;
            if (div_start) begin
              state <= S_DIV;
            end else begin
              res.found     <= 1'b0;
              res.status    <= lphs_pkg::STAT_ABSENT;
              res.slot_used <= '0;
              state         <= S_FIN;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            idx   <= div_rem[IW-1:0];
            cnt   <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          res.slot_used <= slot_out;
          state         <= S_FIN;
          if (mode == lphs_pkg::MODE_INSERT) begin
            res.found <= 1'b0;
            if (st != lphs_pkg::ST_USED) begin
              slot_status[idx] <= lphs_pkg::ST_USED;
              res.status       <= lphs_pkg::STAT_DONE;
            end else begin
              res.status <= lphs_pkg::STAT_FULL;
              if (!last_probe) begin
                state <= S_READ;
              end
            end
          end else begin
            if (st == lphs_pkg::ST_EMPTY) begin
              res.found  <= 1'b0;
              res.status <= lphs_pkg::STAT_ABSENT;
            end else if (hit) begin
              res.found  <= 1'b1;
              res.status <= lphs_pkg::STAT_DONE;
              if (mode == lphs_pkg::MODE_REMOVE) begin
                slot_status[idx] <= lphs_pkg::ST_GONE;
              end
            end else begin
              res.found  <= 1'b0;
              res.status <= lphs_pkg::STAT_ABSENT;
              if (!last_probe) begin
                state <= S_READ;
              end
            end
          end
          if (!last_probe) begin
            idx <= wrap ? '0 : idx_inc[IW-1:0];
            cnt <= cnt + 1'b1;
          end
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid     <= 1'b1;
            rsp.found     <= res.found;
            rsp.status    <= res.status;
            rsp.slot_used <= res.slot_used;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted but block stayed ready");

  a_home_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && div_done |-> div_rem < n_eff)
    else $error("home slot not below slot count");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (cnt < n_eff) && ((CW+1)'(idx) < (CW+1)'(n_eff)))
    else $error("probe beyond active slots");

  a_one_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && rsp.valid && !rsp.ready |=> state == S_FIN)
    else $error("pending response overwritten");

endmodule
`default_nettype wire
